// ===== hdl/mbe_pkg.sv =====
// Package for the multibrot escape-time evaluator: widths, constants, payload
// and command types, and the 32-bit saturation helper.
// No dependencies; every other file in hdl/ uses it by scoped name.
`default_nettype none

package mbe_pkg;

    // Frame and number format
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int FRAC_BITS  = 28;

    // Field widths
    localparam int PIX_W   = 10;
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 31;
    localparam int ITER_W  = 12;
    localparam int EXP_W   = 4;
    localparam int CNT_K_W = 3;
    localparam int IDX_W   = 3;

    // Shared multiplier: one spare bit so magnitudes up to 2^31 stay positive
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int P64_W  = 2 * DATA_W;
    localparam int FL_W   = P64_W - FRAC_BITS;
    localparam int SAT_W  = PROD_W;

    // Exponent limits
    localparam int EXP_MIN = 2;
    localparam int EXP_MAX = 8;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_ORIGIN_RE = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ORIGIN_IM = 3'd1;
    localparam logic [IDX_W-1:0] CFG_STEP_RE   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_STEP_IM   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MAX_ITER  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_RADIUS    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_EXPONENT  = 3'd6;

    // Reset values of the registers
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_RE = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_IM = -32'sd268435456;
    localparam logic [STEP_W-1:0]        RST_STEP_RE   = 31'd10066329;
    localparam logic [STEP_W-1:0]        RST_STEP_IM   = 31'd21474836;
    localparam logic [ITER_W-1:0]        RST_MAX_ITER  = 12'd64;
    localparam logic [STEP_W-1:0]        RST_RADIUS    = 31'd805306368;
    localparam logic [EXP_W-1:0]         RST_EXPONENT  = 4'd2;

    // Multiplier operand selection
    localparam logic [3:0] MS_NONE = 4'd0;
    localparam logic [3:0] MS_PX   = 4'd1;
    localparam logic [3:0] MS_PY   = 4'd2;
    localparam logic [3:0] MS_RAD  = 4'd3;
    localparam logic [3:0] MS_RR   = 4'd4;
    localparam logic [3:0] MS_II   = 4'd5;
    localparam logic [3:0] MS_RI   = 4'd6;
    localparam logic [3:0] MS_IR   = 4'd7;
    localparam logic [3:0] MS_QR   = 4'd8;
    localparam logic [3:0] MS_QI   = 4'd9;

    // Use of the registered product
    localparam logic [3:0] AO_NONE   = 4'd0;
    localparam logic [3:0] AO_CR     = 4'd1;
    localparam logic [3:0] AO_CI     = 4'd2;
    localparam logic [3:0] AO_R2     = 4'd3;
    localparam logic [3:0] AO_RE_LD  = 4'd4;
    localparam logic [3:0] AO_RE_SUB = 4'd5;
    localparam logic [3:0] AO_IM_LD  = 4'd6;
    localparam logic [3:0] AO_W      = 4'd7;
    localparam logic [3:0] AO_ADDC   = 4'd8;
    localparam logic [3:0] AO_SQ     = 4'd9;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic              escaped;
        logic [ITER_W-1:0] escape_round;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_re;
        logic signed [DATA_W-1:0] origin_im;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
        logic [ITER_W-1:0]        max_iterations;
        logic [STEP_W-1:0]        escape_radius;
        logic [EXP_W-1:0]         exponent;
    } cfg_t;

    typedef struct packed {
        logic       ld_pix;
        logic       clr_z;
        logic [3:0] mul_sel;
        logic [3:0] acc_op;
    } dp_cmd_t;

    typedef struct packed {
        logic escape;
    } dp_stat_t;

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1]);
        if (fits) begin
            return v[DATA_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mbe_cfg.sv =====
// Configuration register file of the escape-time evaluator.
// Depends on mbe_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module mbe_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mbe_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [mbe_pkg::DATA_W-1:0] cfg_data,
    output mbe_pkg::cfg_t                   cfg
);

    mbe_pkg::cfg_t cfg_reg, cfg_next;

    // Always ready: a word is written in the cycle it arrives
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the index and take the low bits of the word
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mbe_pkg::CFG_ORIGIN_RE: cfg_next.origin_re      = cfg_data;
                mbe_pkg::CFG_ORIGIN_IM: cfg_next.origin_im      = cfg_data;
                mbe_pkg::CFG_STEP_RE:   cfg_next.step_re        = cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_STEP_IM:   cfg_next.step_im        = cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_MAX_ITER:  cfg_next.max_iterations = cfg_data[mbe_pkg::ITER_W-1:0];
                mbe_pkg::CFG_RADIUS:    cfg_next.escape_radius  = cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_EXPONENT:  cfg_next.exponent       = cfg_data[mbe_pkg::EXP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_re      <= mbe_pkg::RST_ORIGIN_RE;
            cfg_reg.origin_im      <= mbe_pkg::RST_ORIGIN_IM;
            cfg_reg.step_re        <= mbe_pkg::RST_STEP_RE;
            cfg_reg.step_im        <= mbe_pkg::RST_STEP_IM;
            cfg_reg.max_iterations <= mbe_pkg::RST_MAX_ITER;
            cfg_reg.escape_radius  <= mbe_pkg::RST_RADIUS;
            cfg_reg.exponent       <= mbe_pkg::RST_EXPONENT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mbe_dp.sv =====
// Datapath of the escape-time evaluator: pixel register, one shared 33x33
// signed multiplier with registered product, point, z, w and magnitude registers.
// Depends on mbe_pkg; driven by commands from mbe_ctrl.
`default_nettype none

module mbe_dp (
    input  wire logic            aclk,
    input  wire mbe_pkg::pixel_t s_data,
    input  wire mbe_pkg::cfg_t   cfg,
    input  wire mbe_pkg::dp_cmd_t cmd,
    output mbe_pkg::dp_stat_t    stat
);

    localparam int DW  = mbe_pkg::DATA_W;
    localparam int MW  = mbe_pkg::MUL_W;
    localparam int PW  = mbe_pkg::PROD_W;
    localparam int P64 = mbe_pkg::P64_W;
    localparam int FW  = mbe_pkg::FL_W;
    localparam int SW  = mbe_pkg::SAT_W;
    localparam int XW  = mbe_pkg::PIX_W;

    logic [XW-1:0]          px_reg, py_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [DW-1:0]   cr_reg, ci_reg;
    logic signed [DW-1:0]   zr_reg, zi_reg, wr_reg, wi_reg;
    logic signed [FW:0]     acc_re_reg, acc_im_reg;
    logic [P64-1:0]         r2_reg, sq_reg;

    logic [XW-1:0]          px_clamp, py_clamp;
    logic signed [MW-1:0]   op_a, op_b;
    logic signed [MW-1:0]   zr_ext, zi_ext, wr_ext, wi_ext, zr_abs, zi_abs;
    logic signed [FW-1:0]   fl_val;
    logic signed [FW:0]     fl_ext, im_sum;
    logic signed [SW-1:0]   cr_sum, ci_sum;
    logic signed [MW-1:0]   add_re, add_im;
    logic [P64-1:0]         mag_sum;

    // Clamp pixel coordinates to the frame
    always_comb begin
        px_clamp = s_data.pixel_x;
        py_clamp = s_data.pixel_y;
        if (int'(s_data.pixel_x) > mbe_pkg::MAX_WIDTH - 1) begin
            px_clamp = XW'(mbe_pkg::MAX_WIDTH - 1);
        end
        if (int'(s_data.pixel_y) > mbe_pkg::MAX_HEIGHT - 1) begin
            py_clamp = XW'(mbe_pkg::MAX_HEIGHT - 1);
        end
    end

    // Extend z and w by one bit and form the magnitudes of z
    assign zr_ext = {zr_reg[DW-1], zr_reg};
    assign zi_ext = {zi_reg[DW-1], zi_reg};
    assign wr_ext = {wr_reg[DW-1], wr_reg};
    assign wi_ext = {wi_reg[DW-1], wi_reg};
    assign zr_abs = zr_reg[DW-1] ? -zr_ext : zr_ext;
    assign zi_abs = zi_reg[DW-1] ? -zi_ext : zi_ext;

    // Select multiplier operands
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            mbe_pkg::MS_PX: begin
                op_a = {{(MW-XW){1'b0}}, px_reg};
                op_b = {{(MW-mbe_pkg::STEP_W){1'b0}}, cfg.step_re};
            end
            mbe_pkg::MS_PY: begin
                op_a = {{(MW-XW){1'b0}}, py_reg};
                op_b = {{(MW-mbe_pkg::STEP_W){1'b0}}, cfg.step_im};
            end
            mbe_pkg::MS_RAD: begin
                op_a = {{(MW-mbe_pkg::STEP_W){1'b0}}, cfg.escape_radius};
                op_b = {{(MW-mbe_pkg::STEP_W){1'b0}}, cfg.escape_radius};
            end
            mbe_pkg::MS_RR: begin
                op_a = wr_ext;
                op_b = zr_ext;
            end
            mbe_pkg::MS_II: begin
                op_a = wi_ext;
                op_b = zi_ext;
            end
            mbe_pkg::MS_RI: begin
                op_a = wr_ext;
                op_b = zi_ext;
            end
            mbe_pkg::MS_IR: begin
                op_a = wi_ext;
                op_b = zr_ext;
            end
            mbe_pkg::MS_QR: begin
                op_a = zr_abs;
                op_b = zr_abs;
            end
            mbe_pkg::MS_QI: begin
                op_a = zi_abs;
                op_b = zi_abs;
            end
            default: ;
        endcase
    end

    // Product shifted down by the fraction width, rounding toward minus infinity
    assign fl_val = prod_reg[P64-1:mbe_pkg::FRAC_BITS];
    assign fl_ext = {fl_val[FW-1], fl_val};
    assign im_sum = acc_im_reg + fl_ext;

    // Point, z + c and magnitude sums
    assign cr_sum  = prod_reg + {{(SW-DW){cfg.origin_re[DW-1]}}, cfg.origin_re};
    assign ci_sum  = prod_reg + {{(SW-DW){cfg.origin_im[DW-1]}}, cfg.origin_im};
    assign add_re  = wr_ext + {cr_reg[DW-1], cr_reg};
    assign add_im  = wi_ext + {ci_reg[DW-1], ci_reg};
    assign mag_sum = sq_reg + prod_reg[P64-1:0];

    assign stat.escape = mag_sum > r2_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (cmd.ld_pix) begin
            px_reg <= px_clamp;
            py_reg <= py_clamp;
        end
        if (cmd.clr_z) begin
            zr_reg <= '0;
            zi_reg <= '0;
            wr_reg <= '0;
            wi_reg <= '0;
        end
        case (cmd.acc_op)
            mbe_pkg::AO_CR:     cr_reg     <= mbe_pkg::sat_data(cr_sum);
            mbe_pkg::AO_CI:     ci_reg     <= mbe_pkg::sat_data(ci_sum);
            mbe_pkg::AO_R2:     r2_reg     <= prod_reg[P64-1:0];
            mbe_pkg::AO_RE_LD:  acc_re_reg <= fl_ext;
            mbe_pkg::AO_RE_SUB: acc_re_reg <= acc_re_reg - fl_ext;
            mbe_pkg::AO_IM_LD:  acc_im_reg <= fl_ext;
            mbe_pkg::AO_W: begin
                wr_reg <= mbe_pkg::sat_data({{(SW-FW-1){acc_re_reg[FW]}}, acc_re_reg});
                wi_reg <= mbe_pkg::sat_data({{(SW-FW-1){im_sum[FW]}}, im_sum});
            end
            mbe_pkg::AO_ADDC: begin
                zr_reg <= mbe_pkg::sat_data({{(SW-MW){add_re[MW-1]}}, add_re});
                zi_reg <= mbe_pkg::sat_data({{(SW-MW){add_im[MW-1]}}, add_im});
                wr_reg <= mbe_pkg::sat_data({{(SW-MW){add_re[MW-1]}}, add_re});
                wi_reg <= mbe_pkg::sat_data({{(SW-MW){add_im[MW-1]}}, add_im});
            end
            mbe_pkg::AO_SQ:     sq_reg     <= prod_reg[P64-1:0];
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/mbe_ctrl.sv =====
// Controller of the escape-time evaluator: sequencer over the shared
// multiplier, round and product counters, and the result register.
// Depends on mbe_pkg; commands mbe_dp and reads its escape status.
`default_nettype none

module mbe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mbe_pkg::result_t       m_data,
    input  wire mbe_pkg::cfg_t     cfg,
    output mbe_pkg::dp_cmd_t       cmd,
    input  wire mbe_pkg::dp_stat_t stat
);

    localparam int IW = mbe_pkg::ITER_W;
    localparam int KW = mbe_pkg::CNT_K_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PX   = 4'd1;
    localparam logic [3:0] S_PY   = 4'd2;
    localparam logic [3:0] S_RAD  = 4'd3;
    localparam logic [3:0] S_R2   = 4'd4;
    localparam logic [3:0] S_M0   = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_M3   = 4'd8;
    localparam logic [3:0] S_M4   = 4'd9;
    localparam logic [3:0] S_ADD  = 4'd10;
    localparam logic [3:0] S_Q0   = 4'd11;
    localparam logic [3:0] S_Q1   = 4'd12;
    localparam logic [3:0] S_CMP  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [IW-1:0]    d_reg, d_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             esc_reg, esc_next;
    logic [IW-1:0]    round_reg, round_next;
    logic             m_valid_reg, m_valid_next;
    mbe_pkg::result_t res_reg, res_next;

    logic [mbe_pkg::EXP_W-1:0] p_eff;
    logic [KW-1:0]    n_mul;
    logic             last_mul, last_round, out_free;

    // Clamp the exponent; p-1 complex products per round
    always_comb begin
        p_eff = cfg.exponent;
        if (int'(cfg.exponent) < mbe_pkg::EXP_MIN) begin
            p_eff = mbe_pkg::EXP_W'(mbe_pkg::EXP_MIN);
        end else if (int'(cfg.exponent) > mbe_pkg::EXP_MAX) begin
            p_eff = mbe_pkg::EXP_W'(mbe_pkg::EXP_MAX);
        end
    end
    assign n_mul      = KW'(p_eff - 4'd1);
    assign last_mul   = ({1'b0, k_reg} + {{KW{1'b0}}, 1'b1}) == {1'b0, n_mul};
    assign last_round = ({1'b0, d_reg} + {{IW{1'b0}}, 1'b1}) == {1'b0, cfg.max_iterations};
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    // Sequence the datapath and step the counters
    always_comb begin
        state_next   = state_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        esc_next     = esc_reg;
        round_next   = round_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        cmd.ld_pix   = 1'b0;
        cmd.clr_z    = 1'b0;
        cmd.mul_sel  = mbe_pkg::MS_NONE;
        cmd.acc_op   = mbe_pkg::AO_NONE;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.ld_pix = 1'b1;
                    state_next = S_PX;
                end
            end
            S_PX: begin
                cmd.mul_sel = mbe_pkg::MS_PX;
                state_next  = S_PY;
            end
            S_PY: begin
                cmd.mul_sel = mbe_pkg::MS_PY;
                cmd.acc_op  = mbe_pkg::AO_CR;
                state_next  = S_RAD;
            end
            S_RAD: begin
                cmd.mul_sel = mbe_pkg::MS_RAD;
                cmd.acc_op  = mbe_pkg::AO_CI;
                cmd.clr_z   = 1'b1;
                state_next  = S_R2;
            end
            S_R2: begin
                cmd.acc_op = mbe_pkg::AO_R2;
                d_next     = '0;
                k_next     = '0;
                esc_next   = 1'b0;
                round_next = '0;
                state_next = (cfg.max_iterations == '0) ? S_DONE : S_M0;
            end
            S_M0: begin
                cmd.mul_sel = mbe_pkg::MS_RR;
                state_next  = S_M1;
            end
            S_M1: begin
                cmd.mul_sel = mbe_pkg::MS_II;
                cmd.acc_op  = mbe_pkg::AO_RE_LD;
                state_next  = S_M2;
            end
            S_M2: begin
                cmd.mul_sel = mbe_pkg::MS_RI;
                cmd.acc_op  = mbe_pkg::AO_RE_SUB;
                state_next  = S_M3;
            end
            S_M3: begin
                cmd.mul_sel = mbe_pkg::MS_IR;
                cmd.acc_op  = mbe_pkg::AO_IM_LD;
                state_next  = S_M4;
            end
            S_M4: begin
                cmd.acc_op = mbe_pkg::AO_W;
                if (last_mul) begin
                    state_next = S_ADD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_M0;
                end
            end
            S_ADD: begin
                cmd.acc_op = mbe_pkg::AO_ADDC;
                state_next = S_Q0;
            end
            S_Q0: begin
                cmd.mul_sel = mbe_pkg::MS_QR;
                state_next  = S_Q1;
            end
            S_Q1: begin
                cmd.mul_sel = mbe_pkg::MS_QI;
                cmd.acc_op  = mbe_pkg::AO_SQ;
                state_next  = S_CMP;
            end
            S_CMP: begin
                if (stat.escape) begin
                    esc_next   = 1'b1;
                    round_next = d_reg;
                    state_next = S_DONE;
                end else if (last_round) begin
                    state_next = S_DONE;
                end else begin
                    d_next     = d_reg + 1'b1;
                    k_next     = '0;
                    state_next = S_M0;
                end
            end
            S_DONE: begin
                // Hold until the result register can take the word
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    res_next.escaped      = esc_reg;
                    res_next.escape_round = round_reg;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        d_reg     <= d_next;
        k_reg     <= k_next;
        esc_reg   <= esc_next;
        round_reg <= round_next;
        res_reg   <= res_next;
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_PX))
        else $error("accepted pixel did not start the point setup");

    a_round_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP && state_next == S_M0) |=> (d_reg == $past(d_reg) + 1'b1))
        else $error("round counter did not advance on a new round");

    a_no_escape_round_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.escaped) |-> (res_reg.escape_round == '0))
        else $error("round reported for a point that did not escape");

    a_result_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> (state_reg == S_DONE))
        else $error("result word raised outside the finishing state");

endmodule

`default_nettype wire

// ===== hdl/multibrot_escape_time.sv =====
// Top level of the multibrot escape-time evaluator.
// Depends on mbe_pkg and instantiates mbe_cfg, mbe_dp and mbe_ctrl.
//
//   channel   handshake              payload
//   s_        s_valid / s_ready      s_data  : mbe_pkg::pixel_t  (pixel_x, pixel_y)
//   m_        m_valid / m_ready      m_data  : mbe_pkg::result_t (escaped, escape_round)
//   cfg_      cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (32 bits)
//
// One pixel at a time: the next pixel is accepted only once the previous one has
// left the finishing state; every product passes through the single 33x33
// multiplier, one at a time.
// Reset is synchronous on aresetn and loads the register defaults.
// A waiting result does not block the next pixel; the finishing cycle waits on m_ready.
`default_nettype none

module multibrot_escape_time (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire mbe_pkg::pixel_t            s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output mbe_pkg::result_t                m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mbe_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [mbe_pkg::DATA_W-1:0] cfg_data
);

    mbe_pkg::cfg_t     cfg;
    mbe_pkg::dp_cmd_t  cmd;
    mbe_pkg::dp_stat_t stat;

    mbe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbe_dp u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

    mbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire
